// ----- hw/rtl/bcm_pkg.sv -----
// Shared types and constants for the binomial coefficient mod prime block.
// No dependencies; imported by every module of the block.
package bcm_pkg;

  localparam int unsigned N_W   = 16;
  localparam int unsigned K_W   = 8;
  localparam int unsigned VAL_W = 30;
  localparam int unsigned MAX_K = 255;
  localparam int unsigned CELLS = MAX_K + 1;

  localparam logic [VAL_W-1:0] PRIME = VAL_W'(1000000007);

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [N_W-1:0]   row_t;
  typedef logic [K_W-1:0]   col_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  // control broadcast to the cell row
  typedef struct packed {
    logic clear;  // zero every cell (start of a query)
    logic step;   // compute the next Pascal row
    logic seed;   // left input of cell 0 is 1 on the first row
  } cell_ctl_t;

endpackage

// ----- hw/rtl/bcm_cell.sv -----
// One entry of the Pascal row: adds its left neighbor's value mod the prime.
// Depends on bcm_pkg.
module bcm_cell
  import bcm_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  val_t      left_in,
  output val_t      value
);

  logic [VAL_W:0] sum;
  val_t           value_next;

  // both operands are below the prime, so one conditional subtract reduces
  always_comb begin
    sum = {1'b0, value} + {1'b0, left_in};
    if (sum >= {1'b0, PRIME}) begin
      value_next = VAL_W'(sum - {1'b0, PRIME});
    end else begin
      value_next = sum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      value <= '0;
    end else if (ctl.step) begin
      value <= value_next;
    end
  end

endmodule

// ----- hw/rtl/bcm_ctrl.sv -----
// Query sequencer: latches (n, k), counts rows and hands the result over.
// Depends on bcm_pkg.
module bcm_ctrl
  import bcm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  row_t      query_n,
  input  col_t      query_k,
  input  logic      out_busy,
  output cell_ctl_t ctl,
  output logic      load_out,
  output logic      zero_result,
  output col_t      sel_k
);

  state_t state, state_next;
  row_t   n_reg;
  col_t   k_reg;
  row_t   row;
  logic   zero_flag;
  logic   accept;
  logic   last_row;

  assign accept   = in_valid && !in_stall;
  assign last_row = (row == n_reg);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ({8'd0, query_k} > query_n) ? ST_FIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_row) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = 1'b1;
    ctl       = '0;
    load_out  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        ctl.clear = in_valid;
      end
      ST_RUN: begin
        ctl.step = 1'b1;
        ctl.seed = (row == '0);
      end
      ST_FIN: begin
        load_out = !out_busy;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // query latch and row counter
  always_ff @(posedge clk) begin
    if (accept) begin
      n_reg     <= query_n;
      k_reg     <= query_k;
      zero_flag <= ({8'd0, query_k} > query_n);
      row       <= '0;
    end else if (state == ST_RUN && !last_row) begin
      row <= row + row_t'(1);
    end
  end

  assign zero_result = zero_flag;
  assign sel_k       = k_reg;

endmodule

// ----- hw/rtl/binomial_coefficient_mod_prime.sv -----
// Top level: C(n,k) mod 1000000007 from a row of Pascal cells.
// Depends on bcm_pkg, bcm_cell, bcm_ctrl.
//
//   channel  handshake            payload
//   input    in_valid / in_stall  query_n[15:0], query_k[7:0]
//   output   out_valid / out_stall coefficient[29:0]
//
// The cells clear at the accept edge, then take n+1 row steps (all cells
// in parallel), and the result is captured once the output register is free.
// With k greater than n there are no row steps and a zero result is captured.
// One query at a time; the next one is taken once the result is captured,
// even while that result still waits behind out_stall.
// rst is synchronous and clears control only; cell contents need no reset.
module binomial_coefficient_mod_prime
  import bcm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  row_t query_n,
  input  col_t query_k,
  output logic out_valid,
  input  logic out_stall,
  output val_t coefficient
);

  cell_ctl_t ctl;
  logic      load_out;
  logic      zero_result;
  col_t      sel_k;
  logic      out_busy;
  val_t      cell_value [CELLS];
  val_t      cell_left  [CELLS];

  assign out_busy = out_valid && out_stall;

  bcm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .query_n     (query_n),
    .query_k     (query_k),
    .out_busy    (out_busy),
    .ctl         (ctl),
    .load_out    (load_out),
    .zero_result (zero_result),
    .sel_k       (sel_k)
  );

  // cell chain: cell 0 sees a 1 only on row 0, every other cell its neighbor
  assign cell_left[0] = ctl.seed ? val_t'(1) : '0;

  for (genvar j = 0; j < CELLS; j++) begin : g_cell
    if (j > 0) begin : g_link
      assign cell_left[j] = cell_value[j-1];
    end
    bcm_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .left_in (cell_left[j]),
      .value   (cell_value[j])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      coefficient <= zero_result ? '0 : cell_value[sel_k];
    end
  end

endmodule
